>>> rtl/core/tiled_background_pixel_fetch_unit_defines.svh
// Assertion macros shared by the tiled background pixel fetch RTL.
`ifndef TILED_BACKGROUND_PIXEL_FETCH_UNIT_DEFINES_SVH
`define TILED_BACKGROUND_PIXEL_FETCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TBPF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TBPF_ASSERT_DELAY(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);
`else
`define TBPF_ASSERT_IMPL(lbl, ante, cons, msg)
`define TBPF_ASSERT_DELAY(lbl, ante, n, cons, msg)
`endif
`endif

>>> rtl/core/tbpf_pkg.sv
// Types and codes of the tiled background pixel fetch unit.
`timescale 1ns / 1ps
`default_nettype none
package tbpf_pkg;
	typedef logic [1:0] opcode_t;
	typedef logic [2:0] cfg_index_t;
	typedef logic [1:0] map_size_t;

	localparam opcode_t OP_VIDEO_WRITE = 2'd0;
	localparam opcode_t OP_COLOR_WRITE = 2'd1;
	localparam opcode_t OP_RENDER      = 2'd2;

	localparam cfg_index_t REG_SCROLL_X   = 3'd0;
	localparam cfg_index_t REG_SCROLL_Y   = 3'd1;
	localparam cfg_index_t REG_MAP_BLOCK  = 3'd2;
	localparam cfg_index_t REG_TILE_BLOCK = 3'd3;
	localparam cfg_index_t REG_MAP_SIZE   = 3'd4;
	localparam cfg_index_t REG_FULL_COLOR = 3'd5;

	localparam map_size_t MAP_SQUARE = 2'd0;
	localparam map_size_t MAP_WIDE   = 2'd1;
	localparam map_size_t MAP_TALL   = 2'd2;
	localparam map_size_t MAP_BOTH   = 2'd3;
endpackage
`default_nettype wire

>>> rtl/core/tbpf_ram.sv
// Generic simple dual-port RAM with a registered read that returns old data on a collision.
`timescale 1ns / 1ps
`default_nettype none
module tbpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/core/tiled_background_pixel_fetch_unit.sv
// Top level of the tiled background pixel fetch unit.
//
// Channel   Direction  Handshake               Payload
// request   in         start, busy             opcode, mem_addr, write_data, line, column
// result    out        done (one-cycle strobe) color, opaque
// config    in         cfg_valid, cfg_ready    cfg_index, cfg_data
//
// A request is taken in every cycle; busy never rises and cfg_ready is always high.
// A render request gives its result after one map read, one character read and one color
// table read in a row, each a registered memory read.
// Writes do not stall: each read lands after the writes of earlier requests and no later
// than the writes of later ones, so no forwarding is needed. Palette writes are done in stage 2.
// The memories have no reset; reset clears the config registers and the pipeline valid bits.
`timescale 1ns / 1ps
`default_nettype none
`include "tiled_background_pixel_fetch_unit_defines.svh"
module tiled_background_pixel_fetch_unit #(
	parameter int VIDEO_BYTES     = 131072,
	parameter int PALETTE_ENTRIES = 256,
	parameter int LINE_WIDTH      = 240
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire tbpf_pkg::opcode_t    opcode,
	input  wire logic [16:0]          mem_addr,
	input  wire logic [31:0]          write_data,
	input  wire logic [7:0]           line,
	input  wire logic [7:0]           column,
	output logic                      done,
	output logic [31:0]               color,
	output logic                      opaque,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire tbpf_pkg::cfg_index_t cfg_index,
	input  wire logic [8:0]           cfg_data
);
	import tbpf_pkg::*;

	localparam int VA = $clog2(VIDEO_BYTES);
	localparam int PA = $clog2(PALETTE_ENTRIES);
	localparam logic [17:0] VB_W = 18'(VIDEO_BYTES);
	localparam logic [9:0] LW_W = 10'(LINE_WIDTH);
	localparam int RECIP_SHIFT = 26;
	localparam logic [18:0] RECIP = 19'((64'd1 << RECIP_SHIFT) / PALETTE_ENTRIES);
	localparam logic [16:0] PE_W = 17'(PALETTE_ENTRIES);

	function automatic logic [VA-1:0] vwrap(input logic [16:0] a);
		logic [17:0] ext;
		ext = {1'b0, a};
		if (ext >= VB_W) begin
			ext = ext - VB_W;
		end
		return ext[VA-1:0];
	endfunction

	logic [8:0] scroll_x_q, scroll_y_q;
	logic [4:0] map_block_q;
	logic [1:0] tile_block_q;
	map_size_t  map_size_q;
	logic       full_color_q;

	logic accept, vid_we, pal_we, render;
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign vid_we    = accept && (opcode == OP_VIDEO_WRITE);
	assign pal_we    = accept && (opcode == OP_COLOR_WRITE);
	assign render    = accept && (opcode == OP_RENDER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scroll_x_q   <= '0;
			scroll_y_q   <= '0;
			map_block_q  <= '0;
			tile_block_q <= '0;
			map_size_q   <= MAP_SQUARE;
			full_color_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SCROLL_X:   scroll_x_q   <= cfg_data;
				REG_SCROLL_Y:   scroll_y_q   <= cfg_data;
				REG_MAP_BLOCK:  map_block_q  <= cfg_data[4:0];
				REG_TILE_BLOCK: tile_block_q <= cfg_data[1:0];
				REG_MAP_SIZE:   map_size_q   <= cfg_data[1:0];
				REG_FULL_COLOR: full_color_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage 0: scroll, tile map address and video writes.
	logic [8:0]    px, py;
	logic [5:0]    tx, ty;
	logic [16:0]   map_extra, maddr;
	logic [VA-1:0] map_addr, vid_waddr;
	logic          blank;

	assign px    = 9'(column) + scroll_x_q;
	assign py    = 9'(line) + scroll_y_q;
	assign tx    = px[8:3];
	assign ty    = py[8:3];
	assign blank = {2'b00, column} >= LW_W;

	always_comb begin
		unique case (map_size_q)
			MAP_SQUARE: map_extra = '0;
			MAP_WIDE:   map_extra = 17'({tx[5], 11'd0});
			MAP_TALL:   map_extra = 17'({ty[5], 11'd0});
			MAP_BOTH:   map_extra = 17'({ty[5], tx[5], 11'd0});
			default:    map_extra = '0;
		endcase
	end

	assign maddr = 17'({map_block_q, 11'd0}) + 17'({ty[4:0], 6'd0})
		+ 17'({tx[4:0], 1'b0}) + map_extra;
	assign map_addr  = vwrap(maddr);
	assign vid_waddr = vwrap(mem_addr);

	logic [7:0] map_lo, map_hi, char_byte;

	tbpf_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES / 2)) u_map_even (
		.clk   (clk),
		.we    (vid_we && !vid_waddr[0]),
		.waddr (vid_waddr[VA-1:1]),
		.wdata (write_data[7:0]),
		.raddr (map_addr[VA-1:1]),
		.rdata (map_lo)
	);

	tbpf_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES / 2)) u_map_odd (
		.clk   (clk),
		.we    (vid_we && vid_waddr[0]),
		.waddr (vid_waddr[VA-1:1]),
		.wdata (write_data[7:0]),
		.raddr (map_addr[VA-1:1]),
		.rdata (map_hi)
	);

	logic        rv_s1, blank_s1, pw_s1;
	logic [2:0]  fx_s1, fy_s1;
	logic [16:0] pa_s1;
	logic [31:0] pd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
			pw_s1 <= 1'b0;
		end else begin
			rv_s1 <= render;
			pw_s1 <= pal_we;
		end
	end

	always_ff @(posedge clk) begin
		blank_s1 <= blank;
		fx_s1    <= px[2:0];
		fy_s1    <= py[2:0];
		pa_s1    <= mem_addr;
		pd_s1    <= write_data;
	end

	// Stage 1: map entry decode and character address.
	logic [15:0]   entry;
	logic [9:0]    tnum;
	logic [2:0]    cx, cy;
	logic [16:0]   caddr;
	logic [VA-1:0] char_addr;
	logic [35:0]   recip_prod;

	assign entry = {map_hi, map_lo};
	assign tnum  = entry[9:0];
	assign cx    = entry[10] ? ~fx_s1 : fx_s1;
	assign cy    = entry[11] ? ~fy_s1 : fy_s1;

	always_comb begin
		if (full_color_q) begin
			caddr = 17'({tile_block_q, 14'd0}) + 17'({tnum, 6'd0}) + 17'({cy, 3'd0})
				+ 17'(cx);
		end else begin
			caddr = 17'({tile_block_q, 14'd0}) + 17'({tnum, 5'd0}) + 17'({cy, 2'd0})
				+ 17'(cx[2:1]);
		end
	end

	assign char_addr  = vwrap(caddr);
	assign recip_prod = 36'(pa_s1) * 36'(RECIP);

	tbpf_ram #(.WIDTH(8), .DEPTH(VIDEO_BYTES)) u_char (
		.clk   (clk),
		.we    (vid_we),
		.waddr (vid_waddr),
		.wdata (write_data[7:0]),
		.raddr (char_addr),
		.rdata (char_byte)
	);

	logic        rv_s2, blank_s2, nib_hi_s2, pw_s2;
	logic [3:0]  bank_s2;
	logic [9:0]  pq_s2;
	logic [16:0] pa_s2;
	logic [31:0] pd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s2 <= 1'b0;
			pw_s2 <= 1'b0;
		end else begin
			rv_s2 <= rv_s1;
			pw_s2 <= pw_s1;
		end
	end

	always_ff @(posedge clk) begin
		blank_s2  <= blank_s1;
		nib_hi_s2 <= cx[0];
		bank_s2   <= entry[15:12];
		pq_s2     <= recip_prod[RECIP_SHIFT +: 10];
		pa_s2     <= pa_s1;
		pd_s2     <= pd_s1;
	end

	// Stage 2: pixel index, color table read and color table write.
	logic [3:0]    nibble;
	logic [7:0]    pix_index;
	logic          pix_zero;
	logic [16:0]   prem_raw, prem;
	logic [PA-1:0] pal_raddr;
	logic [31:0]   pal_rdata;

	assign nibble    = nib_hi_s2 ? char_byte[7:4] : char_byte[3:0];
	assign pix_index = full_color_q ? char_byte : {bank_s2, nibble};
	assign pix_zero  = full_color_q ? (char_byte == 8'd0) : (nibble == 4'd0);
	assign pal_raddr = PA'(pix_index);
	assign prem_raw  = pa_s2 - 17'(pq_s2 * 17'(PALETTE_ENTRIES));
	assign prem      = (prem_raw >= PE_W) ? prem_raw - PE_W : prem_raw;

	tbpf_ram #(.WIDTH(32), .DEPTH(PALETTE_ENTRIES)) u_palette (
		.clk   (clk),
		.we    (pw_s2),
		.waddr (prem[PA-1:0]),
		.wdata (pd_s2),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	logic rv_s3, transp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s3 <= 1'b0;
		end else begin
			rv_s3 <= rv_s2;
		end
	end

	always_ff @(posedge clk) begin
		transp_s3 <= blank_s2 || pix_zero;
	end

	// Stage 3: result.
	assign done   = rv_s3;
	assign opaque = rv_s3 && !transp_s3;
	assign color  = transp_s3 ? 32'd0 : pal_rdata;

	`TBPF_ASSERT_DELAY(a_render_gives_result, start && !busy && opcode == OP_RENDER, 3, done,
		"render request without a result three cycles later")
	`TBPF_ASSERT_IMPL(a_result_from_render, done,
		$past(start && !busy && opcode == OP_RENDER, 3), "result without a render request")
	`TBPF_ASSERT_IMPL(a_transparent_is_zero, done && !opaque, color == 32'd0,
		"transparent result with a nonzero color")
endmodule
`default_nettype wire

>>> tb/sv/tiled_background_pixel_fetch_unit_test.sv
// Self-checking testbench of the tiled background pixel fetch unit.
`timescale 1ns / 1ps
module tiled_background_pixel_fetch_unit_test;
	import tbpf_pkg::*;

	localparam int VIDEO_BYTES     = 131072;
	localparam int PALETTE_ENTRIES = 256;
	localparam int LINE_WIDTH      = 240;
	localparam int PIPE_DEPTH      = 3;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int DIRECTED_ROWS   = 19;

	localparam opcode_t    OP_UNUSED        = 2'd3;
	localparam cfg_index_t REG_UNUSED_FIRST = 3'd6;
	localparam cfg_index_t REG_UNUSED_LAST  = 3'd7;

	typedef struct packed {
		logic [8:0] scroll_x;
		logic [8:0] scroll_y;
		logic [4:0] map_block;
		logic [1:0] tile_block;
		map_size_t  map_size;
		logic       full_color;
	} layer_cfg_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [16:0] mem_addr;
		logic [31:0] write_data;
		logic [7:0]  line;
		logic [7:0]  column;
	} request_t;

	typedef struct packed {
		logic [31:0] color;
		logic        opaque;
	} pixel_t;

	typedef struct packed {
		request_t req;
		logic     pinned;
		pixel_t   want;
	} step_t;

	typedef struct packed {
		logic [5:0] tx;
		logic [5:0] ty;
		logic [2:0] cx;
		logic [2:0] cy;
	} tile_pos_t;

	typedef struct packed {
		logic       opaque;
		logic [7:0] index;
	} color_pick_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	opcode_t     opcode;
	logic [16:0] mem_addr;
	logic [31:0] write_data;
	logic [7:0]  line;
	logic [7:0]  column;
	logic        done;
	logic [31:0] color;
	logic        opaque;
	logic        cfg_valid;
	logic        cfg_ready;
	cfg_index_t  cfg_index;
	logic [8:0]  cfg_data;

	logic   pinned_en;
	pixel_t pinned_pixel;

	logic [7:0]  pred_vid [VIDEO_BYTES];
	logic [31:0] pred_pal [PALETTE_ENTRIES];
	layer_cfg_t  pred_cfg = '0;

	logic [7:0] plan_vid [VIDEO_BYTES];
	bit         vid_written [VIDEO_BYTES];
	bit         pal_written [PALETTE_ENTRIES];
	layer_cfg_t plan_cfg = '0;

	pixel_t pending_pixels [$];
	step_t  directed_steps [DIRECTED_ROWS];

	bit gaps_on = 1'b1;
	int items_sent = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int renders = 0;
	int opaque_pixels = 0;
	int clear_pixels = 0;
	int past_line = 0;
	int video_writes = 0;
	int color_writes = 0;
	int ignored = 0;
	int cfg_writes = 0;

	tiled_background_pixel_fetch_unit #(
		.VIDEO_BYTES(VIDEO_BYTES),
		.PALETTE_ENTRIES(PALETTE_ENTRIES),
		.LINE_WIDTH(LINE_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.mem_addr(mem_addr),
		.write_data(write_data),
		.line(line),
		.column(column),
		.done(done),
		.color(color),
		.opaque(opaque),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic layer_cfg_t apply_register(layer_cfg_t c, cfg_index_t idx, logic [8:0] d);
		layer_cfg_t n;
		n = c;
		case (idx)
			REG_SCROLL_X:   n.scroll_x = d;
			REG_SCROLL_Y:   n.scroll_y = d;
			REG_MAP_BLOCK:  n.map_block = d[4:0];
			REG_TILE_BLOCK: n.tile_block = d[1:0];
			REG_MAP_SIZE:   n.map_size = map_size_t'(d[1:0]);
			REG_FULL_COLOR: n.full_color = d[0];
			default: ;
		endcase
		return n;
	endfunction

	function automatic tile_pos_t locate(layer_cfg_t c, logic [7:0] ln, logic [7:0] col);
		logic [8:0] px;
		logic [8:0] py;
		tile_pos_t p;
		px = {1'b0, col} + c.scroll_x;
		py = {1'b0, ln} + c.scroll_y;
		p.tx = px[8:3];
		p.ty = py[8:3];
		p.cx = px[2:0];
		p.cy = py[2:0];
		return p;
	endfunction

	function automatic logic [16:0] map_entry_addr(layer_cfg_t c, tile_pos_t p);
		logic [16:0] a;
		a = {c.map_block, 11'd0} + {p.ty[4:0], 6'd0} + {p.tx[4:0], 1'b0};
		case (c.map_size)
			MAP_WIDE: a = a + {p.tx[5], 11'd0};
			MAP_TALL: a = a + {p.ty[5], 11'd0};
			MAP_BOTH: a = a + {p.tx[5], 11'd0} + {p.ty[5], 12'd0};
			default: ;
		endcase
		return a;
	endfunction

	function automatic logic [16:0] tile_byte_addr(layer_cfg_t c, tile_pos_t p, logic [15:0] entry);
		logic [2:0]  cx;
		logic [2:0]  cy;
		logic [16:0] a;
		cx = p.cx ^ {3{entry[10]}};
		cy = p.cy ^ {3{entry[11]}};
		if (c.full_color) begin
			a = {c.tile_block, 14'd0} + {entry[9:0], 6'd0} + {cy, 3'd0} + cx;
		end else begin
			a = {c.tile_block, 14'd0} + {entry[9:0], 5'd0} + {cy, 2'd0} + cx[2:1];
		end
		return a;
	endfunction

	function automatic color_pick_t pick_color(layer_cfg_t c, tile_pos_t p, logic [15:0] entry,
			logic [7:0] tile_byte);
		logic [3:0]  nibble;
		color_pick_t k;
		if (c.full_color) begin
			k.index = tile_byte;
			k.opaque = (tile_byte != 8'd0);
		end else begin
			nibble = (p.cx[0] ^ entry[10]) ? tile_byte[7:4] : tile_byte[3:0];
			k.index = {entry[15:12], nibble};
			k.opaque = (nibble != 4'd0);
		end
		return k;
	endfunction

	function automatic pixel_t predict_pixel(logic [7:0] ln, logic [7:0] col);
		tile_pos_t   p;
		logic [16:0] ma;
		logic [16:0] ma_hi;
		logic [15:0] entry;
		logic [16:0] ta;
		color_pick_t k;
		pixel_t      r;
		r = '0;
		if (col < LINE_WIDTH) begin
			p = locate(pred_cfg, ln, col);
			ma = map_entry_addr(pred_cfg, p);
			ma_hi = ma + 17'd1;
			entry = {pred_vid[ma_hi], pred_vid[ma]};
			ta = tile_byte_addr(pred_cfg, p, entry);
			k = pick_color(pred_cfg, p, entry, pred_vid[ta]);
			r.opaque = k.opaque;
			r.color = k.opaque ? pred_pal[k.index] : 32'd0;
		end
		return r;
	endfunction

	function automatic request_t make_request(opcode_t op, logic [16:0] a, logic [31:0] d,
			logic [7:0] ln, logic [7:0] col);
		request_t rq;
		rq.opcode = op;
		rq.mem_addr = a;
		rq.write_data = d;
		rq.line = ln;
		rq.column = col;
		return rq;
	endfunction

	function automatic logic [31:0] video_byte_data();
		logic [31:0] d;
		d = $urandom;
		case ($urandom_range(0, 7))
			0: d[7:0] = 8'd0;
			1: d[3:0] = 4'd0;
			2: d[7:4] = 4'd0;
			default: ;
		endcase
		return d;
	endfunction

	function automatic int gap_length();
		int r;
		if (!gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send(input request_t rq, input logic pinned, input pixel_t want);
		int n;
		n = gap_length();
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		case (rq.opcode)
			OP_VIDEO_WRITE: begin
				plan_vid[rq.mem_addr] = rq.write_data[7:0];
				vid_written[rq.mem_addr] = 1'b1;
			end
			OP_COLOR_WRITE: pal_written[rq.mem_addr % PALETTE_ENTRIES] = 1'b1;
			default: ;
		endcase
		if (rq.opcode != OP_UNUSED)
			items_sent++;
		@(negedge clk);
		start <= 1'b1;
		opcode <= rq.opcode;
		mem_addr <= rq.mem_addr;
		write_data <= rq.write_data;
		line <= rq.line;
		column <= rq.column;
		pinned_en <= pinned;
		pinned_pixel <= want;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic touch_video(input logic [16:0] a, input bit refresh);
		if (!vid_written[a] || (refresh && $urandom_range(0, 7) == 0))
			send(make_request(OP_VIDEO_WRITE, a, video_byte_data(), 8'($urandom), 8'($urandom)),
				1'b0, '0);
	endtask

	task automatic touch_color(input logic [7:0] idx, input bit refresh);
		if (!pal_written[idx] || (refresh && $urandom_range(0, 7) == 0))
			send(make_request(OP_COLOR_WRITE, {9'($urandom), idx}, $urandom, 8'($urandom),
				8'($urandom)), 1'b0, '0);
	endtask

	// Every byte and color that the pixel will read is written first, even past the line end.
	// A tile byte that shares its address with the map entry is left as it is.
	task automatic prepare_pixel(input logic [7:0] ln, input logic [7:0] col, input bit refresh);
		tile_pos_t   p;
		logic [16:0] ma;
		logic [16:0] ma_hi;
		logic [15:0] entry;
		logic [16:0] ta;
		color_pick_t k;
		p = locate(plan_cfg, ln, col);
		ma = map_entry_addr(plan_cfg, p);
		ma_hi = ma + 17'd1;
		touch_video(ma, refresh);
		touch_video(ma_hi, refresh);
		entry = {plan_vid[ma_hi], plan_vid[ma]};
		ta = tile_byte_addr(plan_cfg, p, entry);
		touch_video(ta, refresh && (ta != ma) && (ta != ma_hi));
		k = pick_color(plan_cfg, p, entry, plan_vid[ta]);
		touch_color(k.index, refresh);
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_index_t idx, input logic [8:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		plan_cfg = apply_register(plan_cfg, idx, d);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_layer(input layer_cfg_t t);
		drain();
		repeat (PIPE_DEPTH + 2) @(posedge clk);
		cfg_write(REG_SCROLL_X, t.scroll_x);
		cfg_write(REG_SCROLL_Y, t.scroll_y);
		cfg_write(REG_MAP_BLOCK, {4'($urandom), t.map_block});
		cfg_write(REG_TILE_BLOCK, {7'($urandom), t.tile_block});
		cfg_write(REG_MAP_SIZE, {7'($urandom), t.map_size});
		cfg_write(REG_FULL_COLOR, {8'($urandom), t.full_color});
		cfg_write(cfg_index_t'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), 9'($urandom));
	endtask

	always @(posedge clk) begin : monitor
		pixel_t want;
		logic   took;
		if (arst_n) begin
			took = 1'b0;
			if (done) begin
				took = 1'b1;
				if (pending_pixels.size() == 0) begin
					report_mismatch("result with no request pending", color, 32'd0);
				end else begin
					want = pending_pixels.pop_front();
					if (color !== want.color)
						report_mismatch("color", color, want.color);
					if (opaque !== want.opaque)
						report_mismatch("opaque", 32'(opaque), 32'(want.opaque));
				end
			end
			if (start && !busy) begin
				took = 1'b1;
				case (opcode)
					OP_VIDEO_WRITE: begin
						pred_vid[mem_addr] = write_data[7:0];
						video_writes++;
					end
					OP_COLOR_WRITE: begin
						pred_pal[mem_addr % PALETTE_ENTRIES] = write_data;
						color_writes++;
					end
					OP_RENDER: begin
						want = pinned_en ? pinned_pixel : predict_pixel(line, column);
						pending_pixels.push_back(want);
						renders++;
						if (column >= LINE_WIDTH)
							past_line++;
						else if (want.opaque)
							opaque_pixels++;
						else
							clear_pixels++;
					end
					default: ignored++;
				endcase
			end
			if (cfg_valid && cfg_ready) begin
				took = 1'b1;
				pred_cfg = apply_register(pred_cfg, cfg_index, cfg_data);
				cfg_writes++;
			end
			quiet_cycles = took ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired after %0d cycles without progress.", quiet_cycles);
				$display("tiled_background_pixel_fetch_unit_test NOT OK");
				$finish;
			end
		end
	end

	initial begin : stimulus
		layer_cfg_t target;
		logic [7:0] ln;
		logic [7:0] col;
		int         run;
		int         r;
		int         phase_end;

		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_VIDEO_WRITE;
		mem_addr = '0;
		write_data = '0;
		line = '0;
		column = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SCROLL_X;
		cfg_data = '0;
		pinned_en = 1'b0;
		pinned_pixel = '0;

		directed_steps = '{
			{OP_VIDEO_WRITE, 17'h00000, 32'h0000_0005, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
			{OP_VIDEO_WRITE, 17'h00001, 32'h0000_0030, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
			{OP_VIDEO_WRITE, 17'h000A0, 32'h0000_000A, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
			{OP_COLOR_WRITE, 17'h0003A, 32'hDEAD_BEEF, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
			{OP_COLOR_WRITE, 17'h1FF30, 32'h0BAD_F00D, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
			{OP_RENDER,      17'h00000, 32'h0000_0000, 8'd0,   8'd0,   1'b1, 32'hDEAD_BEEF, 1'b1},
			{OP_RENDER,      17'h00000, 32'h0000_0000, 8'd0,   8'd1,   1'b1, 32'h0, 1'b0},
			{OP_RENDER,      17'h1FFFF, 32'hFFFF_FFFF, 8'd0,   8'd240, 1'b1, 32'h0, 1'b0},
			{OP_RENDER,      17'h00000, 32'h0000_0000, 8'd0,   8'd255, 1'b1, 32'h0, 1'b0},
			{OP_VIDEO_WRITE, 17'h00002, 32'h0000_0006, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
			{OP_VIDEO_WRITE, 17'h00003, 32'h0000_000C, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
			{OP_VIDEO_WRITE, 17'h000DF, 32'h0000_0070, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
			{OP_COLOR_WRITE, 17'h00007, 32'h1234_5678, 8'd0,   8'd0,   1'b0, 32'h0, 1'b0},
			{OP_RENDER,      17'h00000, 32'h0000_0000, 8'd0,   8'd8,   1'b0, 32'h0, 1'b0},
			{OP_RENDER,      17'h00000, 32'h0000_0000, 8'd255, 8'd239, 1'b0, 32'h0, 1'b0},
			{OP_RENDER,      17'h00000, 32'h0000_0000, 8'd159, 8'd0,   1'b0, 32'h0, 1'b0},
			{OP_UNUSED,      17'h1FFFF, 32'hFFFF_FFFF, 8'd255, 8'd255, 1'b0, 32'h0, 1'b0},
			{OP_VIDEO_WRITE, 17'h1FFFF, 32'hFFFF_FFFF, 8'd255, 8'd255, 1'b0, 32'h0, 1'b0},
			{OP_COLOR_WRITE, 17'h1FFFF, 32'hFFFF_FFFF, 8'd255, 8'd255, 1'b0, 32'h0, 1'b0}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_steps[i].req.opcode == OP_RENDER)
				prepare_pixel(directed_steps[i].req.line, directed_steps[i].req.column, 1'b0);
			send(directed_steps[i].req, directed_steps[i].pinned, directed_steps[i].want);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: target = '0;
				1: target = '1;
				default: begin
					target = $urandom;
					target.map_size = map_size_t'(phase % 4);
					target.full_color = 1'(phase % 2);
				end
			endcase
			program_layer(target);
			gaps_on = ($urandom_range(0, 3) != 0);
			phase_end = items_sent + ITEMS_PER_PHASE;
			while (items_sent < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					// A run of neighboring pixels on one scanline, mostly inside the screen.
					ln = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 159));
					col = 8'($urandom);
					run = $urandom_range(1, 12);
					for (int k = 0; k < run; k++) begin
						prepare_pixel(ln, col, 1'b1);
						send(make_request(OP_RENDER, 17'($urandom), $urandom, ln, col), 1'b0, '0);
						col = col + 8'd1;
					end
				end else if (r < 80) begin
					send(make_request(OP_VIDEO_WRITE, 17'($urandom), video_byte_data(),
						8'($urandom), 8'($urandom)), 1'b0, '0);
				end else if (r < 88) begin
					send(make_request(OP_COLOR_WRITE, 17'($urandom), $urandom, 8'($urandom),
						8'($urandom)), 1'b0, '0);
				end else if (r < 93) begin
					send(make_request(OP_UNUSED, 17'($urandom), $urandom, 8'($urandom),
						8'($urandom)), 1'b0, '0);
				end else if (r < 95) begin
					drain();
				end else begin
					gaps_on = !gaps_on;
				end
			end
		end

		drain();
		repeat (PIPE_DEPTH + 2) @(posedge clk);
		$display("Rendered %0d pixels (%0d opaque, %0d transparent, %0d past the line end)",
			renders, opaque_pixels, clear_pixels, past_line);
		$display("over %0d layer settings; %0d video, %0d color, %0d unused, %0d register writes.",
			PHASES + 1, video_writes, color_writes, ignored, cfg_writes);
		if (mismatches == 0) begin
			$display("tiled_background_pixel_fetch_unit_test OK");
		end else begin
			$display("tiled_background_pixel_fetch_unit_test NOT OK");
		end
		$finish;
	end
endmodule
